// File: rtl/rmbm_pkg.sv
// Package with shared types and constants of the running mean buffer merge block.
package rmbm_pkg;

	localparam int POINTS = 1024;
	localparam int DIMS = 4;
	localparam int PT_W = $clog2(POINTS);
	localparam int DIM_W = $clog2(DIMS);
	localparam int ADDR_W = PT_W + DIM_W;
	localparam int DEPTH = POINTS * DIMS;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_NORM = 2'd2;
	localparam logic [1:0] OP_XFER = 2'd3;

	localparam logic [39:0] CNT_MAX = {40{1'b1}};
	localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_MAG = 48'h8000_0000_0000;

	localparam logic [1:0] REG_NUM_POINTS = 2'd0;
	localparam logic [1:0] REG_NUM_DIMS = 2'd1;

	typedef struct packed {
		logic [1:0] operation;
		logic [9:0] point_index;
		logic [1:0] dim_index;
		logic signed [47:0] sample_value;
		logic [31:0] batch_steps;
		logic pass_last;
	} in_req_t;

	typedef struct packed {
		logic signed [47:0] out_value;
		logic signed [47:0] out_peak;
		logic [39:0] step_count;
		logic count_saturated;
	} out_req_t;

	// Control from the sequencer to the divider.
	typedef struct packed {
		logic start;
		logic [87:0] num;
		logic [40:0] den;
	} div_cmd_t;

endpackage

// File: rtl/rmbm_div.sv
// Radix-2 restoring divider: an 88-bit magnitude divided by a 41-bit divisor.
module rmbm_div (
	input logic clk,
	input logic arst_n,
	input rmbm_pkg::div_cmd_t cmd,
	output logic busy,
	output logic done,
	output logic [87:0] quot
);

	logic [6:0] cnt_q;
	logic [87:0] q_q;
	logic [41:0] rem_q;
	logic [40:0] den_q;
	logic [41:0] trial;
	logic fit;

	assign trial = {rem_q[40:0], q_q[87]};
	assign fit = trial >= {1'b0, den_q};
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (cmd.start) begin
				busy <= 1'b1;
				cnt_q <= 7'd87;
			end else if (busy) begin
				if (cnt_q == 7'd0) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q <= cmd.num;
			rem_q <= '0;
			den_q <= cmd.den;
		end else if (busy) begin
			rem_q <= fit ? trial - {1'b0, den_q} : trial;
			q_q <= {q_q[86:0], fit};
		end
	end

endmodule

// File: rtl/running_mean_buffer_merge.sv
// Top level of the running mean buffer merge block.
// The block keeps a store of POINTS x DIMS signed Q24.24 means, one peak per
// dimension and a 40-bit step count. Requests enter on in_valid/in_ready as an
// in_req_t; each gives one result on out_valid/out_ready as an out_req_t.
// Configuration (num_points at 0x0, num_dims at 0x4) is written by the user
// through the APB-style port while the block is idle, which the block itself
// does not enforce; reads return the registers. A clear, a transfer, an
// out-of-range request and a normalize with a zero count give their result
// after a read of the registered-read mean memory, an update and, when in
// range, a write back, then the output register. A normalize with a nonzero
// count and an append also wait in S_DIV for the 88-step bit-serial divider;
// for an append the product count*old is formed before that in S_MUL1 and
// S_MUL2 with 24x40-bit partial products. One request is worked on at a time,
// and the next can be accepted in the cycle after the result register loads.
// After reset a clearing pass writes zero to all 4096 memory entries, one per
// cycle, during which no request is accepted; configuration writes still go.
// When the receiver stalls, the result is held in the output register and the
// block accepts the next request, which waits until that register frees up.
module running_mean_buffer_merge (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rmbm_pkg::in_req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rmbm_pkg::out_req_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_READ, S_CALC, S_MUL1, S_MUL2, S_ADD, S_DIV, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic [rmbm_pkg::ADDR_W-1:0] clr_q;
	logic [10:0] num_points_q;
	logic [2:0] num_dims_q;
	logic [39:0] steps_q;
	logic signed [47:0] peak_q [rmbm_pkg::DIMS];
	rmbm_pkg::in_req_t req_q;
	logic ok_q, dim_ok_q;

	// Mean memory, one write port and one registered read port.
	logic signed [47:0] mem [rmbm_pkg::DEPTH];
	logic mem_we;
	logic [rmbm_pkg::ADDR_W-1:0] mem_waddr, addr_q;
	logic signed [47:0] mem_wdata, rd_data;

	logic signed [47:0] old_q, val_q;
	logic [87:0] prod_q, p0_q, p1_q;
	logic neg_q;
	rmbm_pkg::div_cmd_t div_cmd;
	logic div_busy, div_done;
	logic [87:0] div_quot;
	logic div_go;
	logic [87:0] div_num_q;
	logic [40:0] div_den_q;

	logic out_full_q;
	rmbm_pkg::out_req_t out_q;

	assign pready = 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_full_q;
	assign out_data = out_q;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			1'b0: prdata = {21'd0, num_points_q};
			default: prdata = {29'd0, num_dims_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_data <= mem[addr_q];
	end

	assign div_cmd.start = div_go;
	assign div_cmd.num = div_num_q;
	assign div_cmd.den = div_den_q;

	rmbm_div u_div (
		.clk(clk), .arst_n(arst_n), .cmd(div_cmd),
		.busy(div_busy), .done(div_done), .quot(div_quot)
	);

	// Magnitudes and helpers.
	logic [47:0] old_mag, s_mag, qsat;
	logic [87:0] sum_mag;
	logic sum_neg;
	logic [40:0] cnt_sum;
	logic [47:0] peak_mag, val_mag;
	always_comb begin
		old_mag = old_q[47] ? 48'(-old_q) : old_q;
		s_mag = req_q.sample_value[47] ? 48'(-req_q.sample_value) : req_q.sample_value;
		if (old_q[47] == req_q.sample_value[47]) begin
			sum_mag = prod_q + {40'd0, s_mag};
			sum_neg = old_q[47];
		end else if (prod_q >= {40'd0, s_mag}) begin
			sum_mag = prod_q - {40'd0, s_mag};
			sum_neg = old_q[47];
		end else begin
			sum_mag = {40'd0, s_mag} - prod_q;
			sum_neg = req_q.sample_value[47];
		end
		cnt_sum = {1'b0, steps_q} + {9'd0, req_q.batch_steps};
		if (neg_q) qsat = (div_quot > {40'd0, rmbm_pkg::NEG_MAG}) ? rmbm_pkg::NEG_MAG
			: div_quot[47:0];
		else qsat = (div_quot > {40'd0, rmbm_pkg::POS_MAX}) ? rmbm_pkg::POS_MAX
			: div_quot[47:0];
		peak_mag = peak_q[req_q.dim_index[rmbm_pkg::DIM_W-1:0]][47]
			? 48'(-peak_q[req_q.dim_index[rmbm_pkg::DIM_W-1:0]])
			: peak_q[req_q.dim_index[rmbm_pkg::DIM_W-1:0]];
		val_mag = val_q[47] ? 48'(-val_q) : val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			clr_q <= '0;
			num_points_q <= 11'd1024;
			num_dims_q <= 3'd1;
			steps_q <= '0;
			out_full_q <= 1'b0;
			mem_we <= 1'b0;
			div_go <= 1'b0;
			for (int i = 0; i < rmbm_pkg::DIMS; i++) peak_q[i] <= '0;
		end else begin
			mem_we <= 1'b0;
			div_go <= 1'b0;
			if (psel && penable && pwrite) begin
				if (paddr[2:2] == rmbm_pkg::REG_NUM_POINTS[0:0]) num_points_q <= pwdata[10:0];
				else num_dims_q <= pwdata[2:0];
			end
			// While a result waits to load, S_OUT decides the register's fill state.
			if (out_full_q && out_ready && state_q != S_OUT) out_full_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					mem_we <= 1'b1;
					mem_waddr <= clr_q;
					mem_wdata <= '0;
					clr_q <= clr_q + 1'b1;
					if (clr_q == rmbm_pkg::ADDR_W'(rmbm_pkg::DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						dim_ok_q <= ({1'b0, in_data.dim_index} < num_dims_q);
						ok_q <= ({1'b0, in_data.dim_index} < num_dims_q) &&
							({1'b0, in_data.point_index} < num_points_q);
						addr_q <= {in_data.dim_index, in_data.point_index};
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_CALC;
				S_CALC: begin
					old_q <= rd_data;
					val_q <= '0;
					state_q <= S_FIN;
					if (ok_q) begin
						case (req_q.operation)
							rmbm_pkg::OP_APPEND: state_q <= S_MUL1;
							rmbm_pkg::OP_NORM: begin
								val_q <= rd_data;
								if (steps_q != 40'd0) begin
									div_num_q <= {40'd0, rd_data[47] ? 48'(-rd_data) : rd_data};
									div_den_q <= {1'b0, steps_q};
									neg_q <= rd_data[47];
									div_go <= 1'b1;
									state_q <= S_DIV;
								end
							end
							rmbm_pkg::OP_XFER: val_q <= rd_data;
							default: val_q <= '0;
						endcase
					end
				end
				S_MUL1: begin
					p0_q <= 88'(steps_q * old_mag[23:0]);
					p1_q <= 88'(steps_q * old_mag[47:24]);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					prod_q <= p0_q + (p1_q << 24);
					state_q <= S_ADD;
				end
				S_ADD: begin
					div_num_q <= sum_mag;
					div_den_q <= (cnt_sum == 41'd0) ? 41'd1 : cnt_sum;
					neg_q <= sum_neg;
					div_go <= 1'b1;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						val_q <= neg_q ? 48'(-qsat) : qsat;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (ok_q) begin
						mem_we <= 1'b1;
						mem_waddr <= addr_q;
						case (req_q.operation)
							rmbm_pkg::OP_APPEND, rmbm_pkg::OP_NORM: mem_wdata <= val_q;
							default: mem_wdata <= '0;
						endcase
						if (req_q.operation == rmbm_pkg::OP_CLEAR)
							peak_q[req_q.dim_index[rmbm_pkg::DIM_W-1:0]] <= '0;
						if (req_q.operation == rmbm_pkg::OP_APPEND &&
							(req_q.point_index == 10'd0 || val_mag > peak_mag))
							peak_q[req_q.dim_index[rmbm_pkg::DIM_W-1:0]] <= val_q;
					end
					if (req_q.pass_last) begin
						case (req_q.operation)
							rmbm_pkg::OP_CLEAR, rmbm_pkg::OP_NORM: steps_q <= '0;
							rmbm_pkg::OP_APPEND:
								steps_q <= cnt_sum[40] ? rmbm_pkg::CNT_MAX : cnt_sum[39:0];
							default: steps_q <= steps_q;
						endcase
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_full_q || out_ready) begin
						out_full_q <= 1'b1;
						out_q.out_value <= val_q;
						out_q.out_peak <= dim_ok_q
							? peak_q[req_q.dim_index[rmbm_pkg::DIM_W-1:0]] : '0;
						out_q.step_count <= steps_q;
						out_q.count_saturated <= (steps_q == rmbm_pkg::CNT_MAX);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The divider is only ever started from the sequencer while it is free.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> !div_busy) else $error("divider started while busy");
	// A finished quotient only arrives while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV) else $error("stray divider result");
	// No request is taken during the clearing pass.
	a_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INIT |-> !in_ready) else $error("ready during clearing pass");

endmodule
